/* rtl/core/quaternion_rotate_vector_core_macros.svh */
// Assertion macros for the quaternion vector rotation core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef QUATERNION_ROTATE_VECTOR_CORE_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define QRV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define QRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/qrv_pkg.sv */
// Shared constants for the quaternion vector rotation core.
// Quaternion register format and register indexes; no dependencies.
package qrv_pkg;

    // Quaternion component width (signed, fixed)
    localparam int QUAT_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd3;

    // Reset quaternion: identity rotation
    localparam logic signed [QUAT_W-1:0] QUAT_XYZ_RESET = 16'sd0;
    localparam logic signed [QUAT_W-1:0] QUAT_W_RESET   = 16'sd16384;

    typedef logic signed [QUAT_W-1:0] t_quat;

endpackage

/* rtl/core/quaternion_rotate_vector_core.sv */
// Quaternion vector rotation core: five-stage pipeline, matrix from quaternion.
// Depends on qrv_pkg and quaternion_rotate_vector_core_macros.svh.
//
// Usage:
//   Write the quaternion (x, y, z, w) through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   while no vector is in flight. Index 0..3 selects x, y, z, w.
//   Feed vectors on the s_axis channel; each transfer yields one rotated vector
//   on m_axis, with m_axis_tuser flagging saturation of any component.
// Throughput: one vector per cycle; every stage carries its own valid bit, and
//   the nine coefficients are rebuilt per item in stages one and two.
// The critical stage holds nine coefficient-by-vector multipliers in parallel.
// Reset: the pipeline empties and the quaternion becomes identity (w = 1.0).
// Stall: when m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
`include "quaternion_rotate_vector_core_macros.svh"

module quaternion_rotate_vector_core #(
    parameter int VECTOR_BITS    = 24,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [qrv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qrv_pkg::QUAT_W-1:0]        i_cfg_wdata,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: vec_x, vec_y, vec_z, zero fill to whole bytes
    input  logic [((3*VECTOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: rot_x, rot_y, rot_z, zero fill to whole bytes
    output logic [((3*VECTOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: clipped
    output logic                              m_axis_tuser
);
    import qrv_pkg::*;

    localparam int TD_W    = ((3*VECTOR_BITS+7)/8)*8;
    localparam int PQ_W    = 2*QUAT_W;
    localparam int SH      = 2*QUAT_FRAC_BITS;
    localparam int COEF_W  = (SH + 2 > PQ_W + 2) ? SH + 2 : PQ_W + 2;
    localparam int PROD_W  = COEF_W + VECTOR_BITS;
    localparam int SUM_W   = PROD_W + 2;
    localparam int RES_W   = SUM_W - SH;
    localparam int N_STAGE = 5;

    localparam logic signed [COEF_W-1:0] ONE_Q =
        {{(COEF_W-1){1'b0}}, 1'b1} << SH;
    localparam logic signed [SUM_W-1:0] HALF_Q =
        {{(SUM_W-1){1'b0}}, 1'b1} << (SH-1);
    localparam logic signed [VECTOR_BITS-1:0] VMAX = {1'b0, {(VECTOR_BITS-1){1'b1}}};
    localparam logic signed [VECTOR_BITS-1:0] VMIN = {1'b1, {(VECTOR_BITS-1){1'b0}}};

    // Configuration registers
    t_quat r_qx, r_qy, r_qz, r_qw;

    // Pipeline control
    logic [N_STAGE-1:0] r_vld;
    logic               en;

    // Stage payloads
    logic signed [VECTOR_BITS-1:0] r_vec1 [3];
    logic signed [VECTOR_BITS-1:0] r_vec2 [3];
    logic signed [PQ_W-1:0]        r_pxx, r_pyy, r_pzz, r_pxy, r_pxz;
    logic signed [PQ_W-1:0]        r_pxw, r_pyz, r_pyw, r_pzw;
    logic signed [COEF_W-1:0]      r_coef [9];
    logic signed [PROD_W-1:0]      r_prod [9];
    logic signed [SUM_W-1:0]       r_sum  [3];
    logic [VECTOR_BITS-1:0]        r_rot  [3];
    logic                          r_clip;

    logic signed [VECTOR_BITS-1:0] in_vec [3];
    logic signed [COEF_W-1:0]      n_coef [9];
    logic signed [RES_W-1:0]       sh_val [3];
    logic [VECTOR_BITS-1:0]        n_rot  [3];
    logic                          n_clip;

    // Doubled quaternion product at coefficient width
    function automatic logic signed [COEF_W-1:0] dbl(input logic signed [PQ_W-1:0] p);
        logic signed [COEF_W-1:0] e;
        e = COEF_W'(p);
        return e <<< 1;
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= QUAT_XYZ_RESET;
            r_qy <= QUAT_XYZ_RESET;
            r_qz <= QUAT_XYZ_RESET;
            r_qw <= QUAT_W_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_QUAT_X: r_qx <= i_cfg_wdata;
                REG_QUAT_Y: r_qy <= i_cfg_wdata;
                REG_QUAT_Z: r_qz <= i_cfg_wdata;
                REG_QUAT_W: r_qw <= i_cfg_wdata;
                default:    r_qx <= r_qx;
            endcase
        end
    end

    // Advance the whole pipeline unless a result waits at the output
    assign en            = !r_vld[N_STAGE-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STAGE-2:0], s_axis_tvalid};
        end
    end

    // Unpack input vector
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_vec[k] = s_axis_tdata[k*VECTOR_BITS +: VECTOR_BITS];
        end
    end

    // Stage 1: quaternion cross products, capture vector
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec1 <= in_vec;
            r_pxx  <= r_qx * r_qx;
            r_pyy  <= r_qy * r_qy;
            r_pzz  <= r_qz * r_qz;
            r_pxy  <= r_qx * r_qy;
            r_pxz  <= r_qx * r_qz;
            r_pxw  <= r_qx * r_qw;
            r_pyz  <= r_qy * r_qz;
            r_pyw  <= r_qy * r_qw;
            r_pzw  <= r_qz * r_qw;
        end
    end

    // Stage 2: matrix coefficients, row major
    always_comb begin
        n_coef[0] = ONE_Q - dbl(r_pyy) - dbl(r_pzz);
        n_coef[1] = dbl(r_pxy) - dbl(r_pzw);
        n_coef[2] = dbl(r_pxz) + dbl(r_pyw);
        n_coef[3] = dbl(r_pxy) + dbl(r_pzw);
        n_coef[4] = ONE_Q - dbl(r_pzz) - dbl(r_pxx);
        n_coef[5] = dbl(r_pyz) - dbl(r_pxw);
        n_coef[6] = dbl(r_pxz) - dbl(r_pyw);
        n_coef[7] = dbl(r_pyz) + dbl(r_pxw);
        n_coef[8] = ONE_Q - dbl(r_pyy) - dbl(r_pxx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_coef <= n_coef;
            r_vec2 <= r_vec1;
        end
    end

    // Stage 3: coefficient by vector component products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= PROD_W'(r_coef[k]) * PROD_W'(r_vec2[k % 3]);
            end
        end
    end

    // Stage 4: row sums plus rounding half
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_sum[r] <= SUM_W'(r_prod[3*r]) + SUM_W'(r_prod[3*r+1])
                          + SUM_W'(r_prod[3*r+2]) + HALF_Q;
            end
        end
    end

    // Stage 5: drop fraction bits and saturate
    always_comb begin
        n_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            sh_val[r] = RES_W'(r_sum[r] >>> SH);
            if (sh_val[r] > RES_W'(VMAX)) begin
                n_rot[r] = VMAX;
                n_clip   = 1'b1;
            end else if (sh_val[r] < RES_W'(VMIN)) begin
                n_rot[r] = VMIN;
                n_clip   = 1'b1;
            end else begin
                n_rot[r] = sh_val[r][VECTOR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot  <= n_rot;
            r_clip <= n_clip;
        end
    end

    assign m_axis_tvalid = r_vld[N_STAGE-1];
    assign m_axis_tdata  = TD_W'({r_rot[2], r_rot[1], r_rot[0]});
    assign m_axis_tuser  = r_clip;

    // A held pipeline keeps its occupancy
    `QRV_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !en, $stable(r_vld), "stall moved valid bits")

    // An input transfer lands in the first stage
    `QRV_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0], "accepted vector lost")

    // A clipped result has at least one component at a bound
    `QRV_ASSERT_SAME(a_clip_bound, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (r_rot[0] == VMAX) || (r_rot[0] == VMIN) || (r_rot[1] == VMAX) || (r_rot[1] == VMIN) || (r_rot[2] == VMAX) || (r_rot[2] == VMIN), "clip flag without saturated component")

endmodule
